@@ design/utf8vd_pkg.sv @@
package utf8vd_pkg;

   localparam int unsigned CP_WIDTH = 21;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned COUNT_WIDTH = 3;

   localparam logic [CP_WIDTH-1:0] REPLACEMENT = 21'h00FFFD;
   localparam logic [CP_WIDTH-1:0] MAX_SCALAR = 21'h10FFFF;
   localparam logic [CP_WIDTH-1:0] SURR_LO = 21'h00D800;
   localparam logic [CP_WIDTH-1:0] SURR_HI = 21'h00DFFF;
   localparam logic [CP_WIDTH-1:0] MIN_TWO = 21'h000080;
   localparam logic [CP_WIDTH-1:0] MIN_THREE = 21'h000800;
   localparam logic [CP_WIDTH-1:0] MIN_FOUR = 21'h010000;
   localparam logic [5:0] CONT_MASK = 6'h3F;

   typedef struct packed {
      logic [1:0]          seq_length;
      logic [1:0]          conts_seen;
      logic [CP_WIDTH-1:0] accum_bits;
   } state_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [CP_WIDTH-1:0]    code_point;
      logic                   ok;
      logic                   text_end;
   } burst_type;

endpackage

@@ design/utf8vd_decode.sv @@
module utf8vd_decode (
   input  utf8vd_pkg::state_type state_cur,
   input  logic [7:0]            byte_in,
   input  logic                  is_last,
   output utf8vd_pkg::state_type state_nxt,
   output utf8vd_pkg::burst_type burst
);
   import utf8vd_pkg::*;

   logic                   open_seq;
   logic                   is_cont;
   logic [CP_WIDTH-1:0]    acc_shift;
   logic [1:0]             conts_inc;
   logic                   complete;
   logic [CP_WIDTH-1:0]    minimum;
   logic                   bad_value;
   logic [COUNT_WIDTH-1:0] pre_count;
   logic                   lead_open;
   logic                   is_ascii;
   logic [1:0]             lead_len;
   logic [CP_WIDTH-1:0]    lead_bits;

   always_comb begin
      open_seq  = (state_cur.seq_length != 2'd0);
      is_cont   = (byte_in[7:6] == 2'b10);
      acc_shift = {state_cur.accum_bits[CP_WIDTH-7:0], byte_in[5:0] & CONT_MASK};
      conts_inc = state_cur.conts_seen + 2'd1;
      complete  = (conts_inc >= state_cur.seq_length);

      case (state_cur.seq_length)
         2'd1: begin
            minimum = MIN_TWO;
         end
         2'd2: begin
            minimum = MIN_THREE;
         end
         default: begin
            minimum = MIN_FOUR;
         end
      endcase
      bad_value = (acc_shift < minimum) || (acc_shift > MAX_SCALAR)
                  || ((acc_shift >= SURR_LO) && (acc_shift <= SURR_HI));

      is_ascii  = (byte_in[7] == 1'b0);
      lead_open = 1'b0;
      lead_len  = 2'd0;
      lead_bits = '0;
      if (byte_in[7:5] == 3'b110) begin
         lead_open = 1'b1;
         lead_len  = 2'd1;
         lead_bits = {{(CP_WIDTH-5){1'b0}}, byte_in[4:0]};
      end else if (byte_in[7:4] == 4'b1110) begin
         lead_open = 1'b1;
         lead_len  = 2'd2;
         lead_bits = {{(CP_WIDTH-4){1'b0}}, byte_in[3:0]};
      end else if (byte_in[7:3] == 5'b11110) begin
         lead_open = 1'b1;
         lead_len  = 2'd3;
         lead_bits = {{(CP_WIDTH-3){1'b0}}, byte_in[2:0]};
      end

      pre_count = open_seq ? ({1'b0, state_cur.conts_seen} + 3'd1) : 3'd0;

      state_nxt        = '0;
      burst.text_end   = is_last;
      burst.code_point = REPLACEMENT;
      burst.ok         = 1'b0;
      burst.count      = '0;

      if (open_seq && is_cont) begin
         if (complete) begin
            burst.count = 3'd1;
            if (!bad_value) begin
               burst.code_point = acc_shift;
               burst.ok         = 1'b1;
            end
         end else if (is_last) begin
            burst.count = {1'b0, conts_inc} + 3'd1;
         end else begin
            state_nxt.seq_length = state_cur.seq_length;
            state_nxt.conts_seen = conts_inc;
            state_nxt.accum_bits = acc_shift;
         end
      end else begin
         if (lead_open) begin
            burst.count = pre_count + (is_last ? 3'd1 : 3'd0);
            if (!is_last) begin
               state_nxt.seq_length = lead_len;
               state_nxt.accum_bits = lead_bits;
            end
         end else begin
            burst.count = pre_count + 3'd1;
            if (is_ascii) begin
               burst.code_point = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, byte_in};
               burst.ok         = 1'b1;
            end
         end
      end
   end

endmodule

@@ design/utf8vd_burst.sv @@
module utf8vd_burst (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  utf8vd_pkg::burst_type burst,
   output logic                  can_load,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,
   output logic                  rsp_tlast,
   output logic [1:0]            rsp_tuser
);
   import utf8vd_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             index_ff, index_in;
   logic [CP_WIDTH-1:0]    cp_ff, cp_in;
   logic                   ok_ff, ok_in;
   logic                   end_ff, end_in;
   logic                   busy;
   logic                   is_final;
   logic                   take;

   always_comb begin
      busy     = (count_ff != '0);
      is_final = ({1'b0, index_ff} == (count_ff - 3'd1));
      take     = busy && rsp_tready;
      can_load = !busy || (take && is_final);

      count_in = count_ff;
      index_in = index_ff;
      cp_in    = cp_ff;
      ok_in    = ok_ff;
      end_in   = end_ff;
      if (load) begin
         count_in = burst.count;
         index_in = 2'd0;
         cp_in    = burst.code_point;
         ok_in    = burst.ok;
         end_in   = burst.text_end;
      end else if (take) begin
         if (is_final) begin
            count_in = '0;
         end else begin
            index_in = index_ff + 2'd1;
         end
      end

      rsp_tvalid = busy;
      rsp_tdata  = {3'b000, is_final ? cp_ff : REPLACEMENT};
      rsp_tlast  = is_final;
      rsp_tuser  = {is_final && end_ff, is_final && ok_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         index_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff  <= cp_in;
      ok_ff  <= ok_in;
      end_ff <= end_in;
   end

endmodule

@@ design/utf8_validating_decoder_core.sv @@
// the first result of a byte is offered in the cycle after the byte is taken
// throughput: one byte per cycle while each byte gives at most one result and the output is not stalled
// a byte giving n results holds the input until its final item is taken
// reset: synchronous, active high; clears the open sequence and the output sequencer
module utf8_validating_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // byte_in
   input  logic        req_tlast,  // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // code_point, zero pad
   output logic        rsp_tlast,  // run_last
   output logic [1:0]  rsp_tuser   // ok, text_end
);
   import utf8vd_pkg::*;

   state_type state_ff, state_in;
   state_type state_nxt;
   burst_type burst;
   logic      can_load;
   logic      accept;

   utf8vd_decode u_decode (
      .state_cur (state_ff),
      .byte_in   (req_tdata),
      .is_last   (req_tlast),
      .state_nxt (state_nxt),
      .burst     (burst)
   );

   utf8vd_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .burst      (burst),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always_comb begin
      req_tready = can_load;
      accept     = req_tvalid && can_load;
      state_in   = accept ? state_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("text end on a non-final item");

   a_ok_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("decoded value before the final item of a byte");

   a_hold_mid_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken in the middle of a burst");

   a_close_on_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> state_ff.seq_length == 2'd0)
      else $error("sequence left open after end of text");

endmodule
